// ===== src/assert_macros.svh =====
// assert_macros.svh: concurrent assertion helpers for the renderer RTL.
// Each use expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);
`define ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define ASSERT_IMPLY(label, pre, post, msg)
`define ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// ===== src/tppr_pkg.sv =====
// tppr_pkg: types and fixed constants of the tile palette pixel renderer.
// No dependencies; used by tppr_rem_unit and the renderer core.
package tppr_pkg;

	localparam int CMD_W   = 2;
	localparam int ADDR_W  = 12;
	localparam int DATA_W  = 24;
	localparam int CODE_W  = 8;
	localparam int COL_W   = 5;
	localparam int ROW_W   = 6;
	localparam int PIXX_W  = 8;
	localparam int PIXY_W  = 9;
	localparam int CHAN_W  = 8;
	localparam int PIXC_W  = 6;

	localparam logic [CMD_W-1:0] CMD_LOAD_TILE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_PAL   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LOAD_COLOR = 2'd2;
	localparam logic [CMD_W-1:0] CMD_DRAW       = 2'd3;

	// palette codes above this fold down by it
	localparam logic [CODE_W-1:0] PAL_FOLD = 8'd128;
	localparam int BYTE_VALS     = 256;
	localparam int PAL_CODE_VALS = 129;
	localparam logic [PIXC_W-1:0] PIX_LAST = 6'd63;

	// remainder unit
	localparam int REM_DVD_W   = 12;
	localparam int REM_LO_W    = 8;
	localparam int REM_W       = 8;
	localparam int REM_SUM_W   = 9;
	localparam int REM_LO_VALS = 256;
	localparam int REM_HI_VALS = 16;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [ADDR_W-1:0] load_address;
		logic [DATA_W-1:0] load_data;
		logic [CODE_W-1:0] tile_code;
		logic [CODE_W-1:0] palette_code;
		logic [COL_W-1:0]  tile_column;
		logic [ROW_W-1:0]  tile_row;
	} req_t;

	typedef struct packed {
		logic [PIXX_W-1:0] pixel_x;
		logic [PIXY_W-1:0] pixel_y;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic              last_pixel;
	} pix_t;

	typedef struct packed {
		logic                 start;
		logic [REM_DVD_W-1:0] dividend;
	} rem_req_t;

	typedef struct packed {
		logic             done;
		logic [REM_W-1:0] remainder;
	} rem_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_DRAW
	} state_t;

endpackage

// ===== src/tppr_rem_unit.sv =====
// tppr_rem_unit: 12-bit store address reduced modulo a fixed store size via registered residue table lookups.
// Depends on tppr_pkg. MODULUS must be 1..256.
module tppr_rem_unit #(
	parameter int MODULUS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tppr_pkg::rem_req_t rem_req,
	output tppr_pkg::rem_rsp_t rem_rsp
);

	// residues of the low byte and of the high nibble weighted by 256
	logic [tppr_pkg::REM_W-1:0] lo_tbl [tppr_pkg::REM_LO_VALS];
	logic [tppr_pkg::REM_W-1:0] hi_tbl [tppr_pkg::REM_HI_VALS];

	logic                           done_q;
	logic [tppr_pkg::REM_W-1:0]     lo_q;
	logic [tppr_pkg::REM_W-1:0]     hi_q;
	logic [tppr_pkg::REM_SUM_W-1:0] sum;

	for (genvar i = 0; i < tppr_pkg::REM_LO_VALS; i++) begin : g_lo_tbl
		assign lo_tbl[i] = tppr_pkg::REM_W'(i % MODULUS);
	end
	for (genvar i = 0; i < tppr_pkg::REM_HI_VALS; i++) begin : g_hi_tbl
		assign hi_tbl[i] = tppr_pkg::REM_W'((i * tppr_pkg::REM_LO_VALS) % MODULUS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= rem_req.start;
		end
	end

	always_ff @(posedge clk) begin
		if (rem_req.start) begin
			lo_q <= lo_tbl[rem_req.dividend[tppr_pkg::REM_LO_W-1:0]];
			hi_q <= hi_tbl[rem_req.dividend[tppr_pkg::REM_DVD_W-1:tppr_pkg::REM_LO_W]];
		end
	end

	// both residues lie below the modulus, so one trial subtract finishes
	assign sum = {1'b0, lo_q} + {1'b0, hi_q};

	assign rem_rsp.done      = done_q;
	assign rem_rsp.remainder = (sum >= tppr_pkg::REM_SUM_W'(MODULUS))
		? tppr_pkg::REM_W'(sum - tppr_pkg::REM_SUM_W'(MODULUS)) : tppr_pkg::REM_W'(sum);

endmodule

// ===== src/tile_palette_pixel_renderer_core.sv =====
// Tile palette pixel renderer: load commands fill tile, palette and colour stores; a draw
// command expands one 8x8 planar 2bpp tile into 64 pixels, one per cycle unless the output
// stalls, in row-major order. Depends on tppr_pkg, tppr_rem_unit and assert_macros.svh.
//
// A tile byte load writes the store as it is taken. Palette and colour loads pass a reduce
// state: the store address is reduced modulo the store size by constant residue tables,
// low byte and high nibble looked up into registers, then summed with one trial subtract;
// the write lands in the same cycle as the sum. A draw issues one pixel a cycle, unless
// the output stalls, through three chained single-port store reads (tile byte, palette
// slot, colour): the command is taken, 64 pixels are issued and the pipeline drains
// through stages s1, s2, s3 and the output register. A stalled output freezes the whole
// pixel pipeline. The last pixel of a draw may wait in the output register while the next
// command is taken. No clearing pass: store contents are undefined until written.
`include "assert_macros.svh"

module tile_palette_pixel_renderer_core #(
	parameter int TILE_COUNT    = 256,
	parameter int PALETTE_COUNT = 64,
	parameter int COLOR_COUNT   = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  tppr_pkg::req_t req,
	output logic           pix_valid,
	input  logic           pix_ready,
	output tppr_pkg::pix_t pix
);

	localparam int TIDX_W  = $clog2(TILE_COUNT);
	localparam int TDEPTH  = TILE_COUNT * 16;
	localparam int TADDR_W = TIDX_W + 4;
	localparam int PIDX_W  = $clog2(PALETTE_COUNT);
	localparam int PDEPTH  = PALETTE_COUNT * 4;
	localparam int PADDR_W = PIDX_W + 2;
	localparam int CIDX_W  = $clog2(COLOR_COUNT);

	// constant modulo tables for the narrow reductions
	logic [TIDX_W-1:0] tile_mod_tbl [tppr_pkg::BYTE_VALS];
	logic [PIDX_W-1:0] pal_mod_tbl  [tppr_pkg::PAL_CODE_VALS];
	logic [CIDX_W-1:0] cidx_mod_tbl [tppr_pkg::BYTE_VALS];

	for (genvar i = 0; i < tppr_pkg::BYTE_VALS; i++) begin : g_byte_tbl
		assign tile_mod_tbl[i] = TIDX_W'(i % TILE_COUNT);
		assign cidx_mod_tbl[i] = CIDX_W'(i % COLOR_COUNT);
	end
	for (genvar i = 0; i < tppr_pkg::PAL_CODE_VALS; i++) begin : g_pal_tbl
		assign pal_mod_tbl[i] = PIDX_W'(i % PALETTE_COUNT);
	end

	// stores
	logic [7:0]                  tile_mem [TDEPTH];
	logic [CIDX_W-1:0]           pal_mem  [PDEPTH];
	logic [tppr_pkg::DATA_W-1:0] col_mem  [COLOR_COUNT];

	tppr_pkg::state_t   state_q, state_d;
	tppr_pkg::rem_req_t pal_rem_req, col_rem_req;
	tppr_pkg::rem_rsp_t pal_rem_rsp, col_rem_rsp;

	logic req_acc;
	logic adv;
	logic issue;
	logic tile_we, pal_we, col_we;

	logic [tppr_pkg::CODE_W-1:0] pal_red;
	logic [TADDR_W-1:0]          tile_wa, tile_ra;
	logic [PADDR_W-1:0]          pal_ra;
	logic [1:0]                  bsel;
	logic [1:0]                  slot;

	// command held over a load or draw
	logic [tppr_pkg::CMD_W-1:0]  cmd_q;
	logic [1:0]                  laddr_q;
	logic [tppr_pkg::DATA_W-1:0] data_q;
	logic [TIDX_W-1:0]           tile_q;
	logic [PIDX_W-1:0]           pal_q;
	logic [tppr_pkg::COL_W-1:0]  col_q;
	logic [tppr_pkg::ROW_W-1:0]  row_q;
	logic [tppr_pkg::PIXC_W-1:0] cnt_q;

	// pixel pipeline
	logic                        v_s1, v_s2, v_s3;
	logic [tppr_pkg::PIXC_W-1:0] cnt_s1, cnt_s2, cnt_s3;
	logic [7:0]                  tile_rd_s1;
	logic [CIDX_W-1:0]           pal_rd_s2;
	logic [tppr_pkg::DATA_W-1:0] col_rd_s3;
	logic                        pix_valid_q;
	tppr_pkg::pix_t              pix_q;

	assign req_acc = req_valid && req_ready;
	assign adv     = !pix_valid_q || pix_ready;

	assign pal_red = (req.palette_code > tppr_pkg::PAL_FOLD)
		? {1'b0, req.palette_code[6:0]} : req.palette_code;

	assign tile_wa = {tile_mod_tbl[req.load_address[11:4]], req.load_address[3:0]};
	// rows 0-3 take bytes 15..8, rows 4-7 bytes 7..0, right to left
	assign tile_ra = {tile_q, ~cnt_q[5], ~cnt_q[2:0]};
	// bit 3 - (row mod 4) and its partner four places up
	assign bsel    = ~cnt_s1[4:3];
	assign slot    = {tile_rd_s1[{1'b1, bsel}], tile_rd_s1[{1'b0, bsel}]};
	assign pal_ra  = {pal_q, slot};

	tppr_rem_unit #(
		.MODULUS (PALETTE_COUNT)
	) u_pal_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rem_req (pal_rem_req),
		.rem_rsp (pal_rem_rsp)
	);

	tppr_rem_unit #(
		.MODULUS (COLOR_COUNT)
	) u_col_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rem_req (col_rem_req),
		.rem_rsp (col_rem_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tppr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d              = state_q;
		req_ready            = 1'b0;
		issue                = 1'b0;
		tile_we              = 1'b0;
		pal_we               = 1'b0;
		col_we               = 1'b0;
		pal_rem_req.start    = 1'b0;
		pal_rem_req.dividend = {2'b00, req.load_address[11:2]};
		col_rem_req.start    = 1'b0;
		col_rem_req.dividend = req.load_address;
		case (state_q)
			tppr_pkg::ST_IDLE: begin
				req_ready = !v_s1 && !v_s2 && !v_s3;
				if (req_acc) begin
					case (req.command)
						tppr_pkg::CMD_LOAD_TILE: begin
							tile_we = 1'b1;
						end
						tppr_pkg::CMD_LOAD_PAL: begin
							pal_rem_req.start = 1'b1;
							state_d           = tppr_pkg::ST_REDUCE;
						end
						tppr_pkg::CMD_LOAD_COLOR: begin
							col_rem_req.start = 1'b1;
							state_d           = tppr_pkg::ST_REDUCE;
						end
						tppr_pkg::CMD_DRAW: begin
							state_d = tppr_pkg::ST_DRAW;
						end
						default: begin
							state_d = tppr_pkg::ST_IDLE;
						end
					endcase
				end
			end
			tppr_pkg::ST_REDUCE: begin
				pal_we = pal_rem_rsp.done && (cmd_q == tppr_pkg::CMD_LOAD_PAL);
				col_we = col_rem_rsp.done && (cmd_q == tppr_pkg::CMD_LOAD_COLOR);
				if (pal_rem_rsp.done || col_rem_rsp.done) begin
					state_d = tppr_pkg::ST_IDLE;
				end
			end
			tppr_pkg::ST_DRAW: begin
				issue = adv;
				if (adv && cnt_q == tppr_pkg::PIX_LAST) begin
					state_d = tppr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tppr_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			cmd_q   <= req.command;
			laddr_q <= req.load_address[1:0];
			data_q  <= req.load_data;
			tile_q  <= tile_mod_tbl[req.tile_code];
			pal_q   <= pal_mod_tbl[pal_red];
			col_q   <= req.tile_column;
			row_q   <= req.tile_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			pix_valid_q <= 1'b0;
		end else begin
			if (req_acc) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (adv) begin
				v_s1        <= issue;
				v_s2        <= v_s1;
				v_s3        <= v_s2;
				pix_valid_q <= v_s3;
			end
		end
	end

	// tile store: load write, draw read
	always_ff @(posedge clk) begin
		if (tile_we) begin
			tile_mem[tile_wa] <= req.load_data[7:0];
		end
		if (issue) begin
			tile_rd_s1 <= tile_mem[tile_ra];
			cnt_s1     <= cnt_q;
		end
	end

	// palette store holds colour indices already reduced
	always_ff @(posedge clk) begin
		if (pal_we) begin
			pal_mem[{pal_rem_rsp.remainder[PIDX_W-1:0], laddr_q}] <= cidx_mod_tbl[data_q[7:0]];
		end
		if (adv) begin
			pal_rd_s2 <= pal_mem[pal_ra];
			cnt_s2    <= cnt_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (col_we) begin
			col_mem[col_rem_rsp.remainder[CIDX_W-1:0]] <= data_q;
		end
		if (adv) begin
			col_rd_s3 <= col_mem[pal_rd_s2];
			cnt_s3    <= cnt_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_q.pixel_x    <= {col_q, cnt_s3[2:0]};
			pix_q.pixel_y    <= {row_q, cnt_s3[5:3]};
			pix_q.red        <= col_rd_s3[23:16];
			pix_q.green      <= col_rd_s3[15:8];
			pix_q.blue       <= col_rd_s3[7:0];
			pix_q.last_pixel <= (cnt_s3 == tppr_pkg::PIX_LAST);
		end
	end

	assign pix_valid = pix_valid_q;
	assign pix       = pix_q;

	`ASSERT_IMPLY(a_busy_blocks_req, state_q != tppr_pkg::ST_IDLE, !req_ready, "request taken while busy")
	`ASSERT_IMPLY(a_rem_done_reduce, pal_rem_rsp.done || col_rem_rsp.done, state_q == tppr_pkg::ST_REDUCE, "stray remainder")
	`ASSERT_IMPLY(a_last_corner, pix_valid && pix.last_pixel, pix.pixel_x[2:0] == 3'd7 && pix.pixel_y[2:0] == 3'd7, "last off corner")
	`ASSERT_NEXT(a_stall_holds_s3, v_s3 && !adv, v_s3 && cnt_s3 == $past(cnt_s3), "stage 3 lost on stall")

endmodule
